@@ sv/rhc_pkg.sv @@
// Shared constants and types for the RGB to HSL converter.
package rhc_pkg;

	localparam int CHAN_W      = 8;
	localparam int HUE_W       = 13;
	localparam int SAT_W       = 8;
	localparam int LIT_W       = 9;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 32;
	localparam int OUT_PAD_W   = OUT_TDATA_W - HUE_W - SAT_W - LIT_W;

	// Full-scale saturation
	localparam int SAT_SCALE   = 255;

	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sector_t;

endpackage

@@ sv/rgb_to_hsl_convert_top.sv @@
// RGB to HSL converter: max/min stage, numerator stage, dividend stage,
// two bit-per-stage dividers and an output stage.
// HQW = bits of the hue quotient; the hue divider resolves one quotient bit per stage.
// Throughput: one pixel per cycle when not stalled; every stage has its own valid bit and
// holds when the stage after it is full and stalled, so bubbles are squeezed out.
// Reset: arst_n clears all valid bits; payload registers are not reset.
module rgb_to_hsl_convert_top #(
	parameter int CHANNEL_BITS  = 8,
	parameter int HUE_FRAC_BITS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// red [7:0], green [15:8], blue [23:16]
	input  logic [rhc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// hue_sixteenths [12:0], sat_level [20:13], lightness_doubled [29:21], zero [31:30]
	output logic [rhc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import rhc_pkg::*;

	localparam int CB    = CHANNEL_BITS;
	localparam int HF    = HUE_FRAC_BITS;
	localparam int BNW   = CB + 3;              // sector base times delta plus difference
	localparam int SECT2 = (60 << HF) * 2;
	localparam int TURN  = 360 << HF;
	localparam int HNW   = CB + HF + 10;        // hue dividend
	localparam int HQW   = $clog2(TURN + 1);
	localparam int SNW   = CB + 9;              // saturation dividend
	localparam int SQW   = SAT_W;
	localparam int NDIV  = HQW;
	localparam logic [CB:0]    FULL2    = (CB + 1)'((2 ** (CB + 1)) - 2);
	localparam logic [HQW-1:0] TURN_Q   = HQW'(TURN);
	localparam logic [HNW-1:0] SECT2_H  = HNW'(SECT2);
	localparam logic [SNW-1:0] SCALE2_S = SNW'(2 * SAT_SCALE);

	// ---------------- stage 1: max, min, sector ----------------
	logic [CB-1:0] r_in, g_in, b_in;
	logic [CB-1:0] hi_c, lo_c;
	sector_t       pick_c;

	logic          v_s1;
	logic          rdy_s1, rdy_s2;
	logic [CB-1:0] r_s1, g_s1, b_s1, hi_s1, lo_s1;
	sector_t       pick_s1;

	assign r_in = CB'(s_axis_tdata[CHAN_W-1:0]);
	assign g_in = CB'(s_axis_tdata[2*CHAN_W-1:CHAN_W]);
	assign b_in = CB'(s_axis_tdata[3*CHAN_W-1:2*CHAN_W]);

	always_comb begin
		hi_c   = r_in;
		lo_c   = r_in;
		pick_c = SECT_RED;
		if (g_in > hi_c) begin
			hi_c   = g_in;
			pick_c = SECT_GREEN;
		end
		if (b_in > hi_c) begin
			hi_c   = b_in;
			pick_c = SECT_BLUE;
		end
		if (g_in < lo_c) lo_c = g_in;
		if (b_in < lo_c) lo_c = b_in;
	end

	assign s_axis_tready = rdy_s1;
	assign rdy_s1 = !v_s1 || rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_axis_tvalid) begin
			r_s1    <= r_in;
			g_s1    <= g_in;
			b_s1    <= b_in;
			hi_s1   <= hi_c;
			lo_s1   <= lo_c;
			pick_s1 <= pick_c;
		end
	end

	// ---------------- stage 2: delta, sum, hue base numerator, sat denominator ----------------
	logic [CB-1:0]  delta_c;
	logic [CB:0]    sum_c, up_c;
	logic [BNW-1:0] bn_c, d_ext;

	logic           v_s2;
	logic [CB-1:0]  delta_s2, den_s2;
	logic [CB:0]    sum_s2;
	logic [BNW-1:0] bn_s2;

	// one per stage from s3 (index 0) through the last divider step (index NDIV)
	logic           v_sd     [NDIV+1];
	logic           rdy_sd   [NDIV+1];
	logic [HNW-1:0] hrem_sd  [NDIV+1];
	logic [CB:0]    hdiv_sd  [NDIV+1];
	logic [HQW-1:0] hq_sd    [NDIV+1];
	logic [SNW-1:0] srem_sd  [NDIV+1];
	logic [CB:0]    sdiv_sd  [NDIV+1];
	logic [SQW-1:0] sq_sd    [NDIV+1];
	logic           gray_sd  [NDIV+1];
	logic [CB:0]    sum_sd   [NDIV+1];

	assign delta_c = hi_s1 - lo_s1;
	assign sum_c   = {1'b0, hi_s1} + {1'b0, lo_s1};
	assign up_c    = FULL2 - sum_c;
	assign d_ext   = BNW'(delta_c);

	always_comb begin
		case (pick_s1)
			SECT_RED: begin
				if (g_s1 >= b_s1)
					bn_c = BNW'(g_s1) - BNW'(b_s1);
				else
					bn_c = (d_ext << 2) + (d_ext << 1) + BNW'(g_s1) - BNW'(b_s1);
			end
			SECT_GREEN: bn_c = (d_ext << 1) + BNW'(b_s1) - BNW'(r_s1);
			SECT_BLUE:  bn_c = (d_ext << 2) + BNW'(r_s1) - BNW'(g_s1);
			default:    bn_c = '0;
		endcase
	end

	assign rdy_s2 = !v_s2 || rdy_sd[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			delta_s2 <= delta_c;
			sum_s2   <= sum_c;
			bn_s2    <= bn_c;
			den_s2   <= (sum_c < up_c) ? CB'(sum_c) : CB'(up_c);
		end
	end

	// ---------------- stage 3: rounded dividends and doubled divisors ----------------
	// round(a / d) = floor((2a + d) / 2d)
	assign rdy_sd[0] = !v_sd[0] || rdy_sd[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sd[0] <= 1'b0;
		end else if (rdy_sd[0]) begin
			v_sd[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_sd[0] && v_s2) begin
			hrem_sd[0] <= HNW'(bn_s2) * SECT2_H + HNW'(delta_s2);
			hdiv_sd[0] <= {delta_s2, 1'b0};
			hq_sd[0]   <= '0;
			srem_sd[0] <= SNW'(delta_s2) * SCALE2_S + SNW'(den_s2);
			sdiv_sd[0] <= {den_s2, 1'b0};
			sq_sd[0]   <= '0;
			gray_sd[0] <= (delta_s2 == '0);
			sum_sd[0]  <= sum_s2;
		end
	end

	// ---------------- divider steps: one quotient bit per stage, MSB first ----------------
	logic v_sf;
	logic rdy_sf;

	genvar j;
	generate
		for (j = 0; j < NDIV; j++) begin : g_div
			localparam int BP = NDIV - 1 - j;

			logic [HNW-1:0] hsh;
			logic           hge;
			logic [SNW-1:0] srem_n;
			logic [SQW-1:0] sq_n;

			assign hsh = HNW'(hdiv_sd[j]) << BP;
			assign hge = hrem_sd[j] >= hsh;

			if (BP < SQW) begin : g_sat
				logic [SNW-1:0] ssh;
				logic           sge;
				assign ssh    = SNW'(sdiv_sd[j]) << BP;
				assign sge    = srem_sd[j] >= ssh;
				assign srem_n = sge ? srem_sd[j] - ssh : srem_sd[j];
				assign sq_n   = sq_sd[j] | (SQW'(sge) << BP);
			end else begin : g_nosat
				assign srem_n = srem_sd[j];
				assign sq_n   = sq_sd[j];
			end

			if (j == NDIV - 1) begin : g_last
				assign rdy_sd[j+1] = !v_sd[j+1] || rdy_sf;
			end else begin : g_mid
				assign rdy_sd[j+1] = !v_sd[j+1] || rdy_sd[j+2];
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_sd[j+1] <= 1'b0;
				end else if (rdy_sd[j+1]) begin
					v_sd[j+1] <= v_sd[j];
				end
			end

			always_ff @(posedge clk) begin
				if (rdy_sd[j+1] && v_sd[j]) begin
					hrem_sd[j+1] <= hge ? hrem_sd[j] - hsh : hrem_sd[j];
					hq_sd[j+1]   <= hq_sd[j] | (HQW'(hge) << BP);
					hdiv_sd[j+1] <= hdiv_sd[j];
					srem_sd[j+1] <= srem_n;
					sq_sd[j+1]   <= sq_n;
					sdiv_sd[j+1] <= sdiv_sd[j];
					gray_sd[j+1] <= gray_sd[j];
					sum_sd[j+1]  <= sum_sd[j];
				end
			end
		end
	endgenerate

	// ---------------- output stage: full-turn wrap, gray override ----------------
	logic [HQW-1:0] hq_fin, hue_c;
	logic [HUE_W-1:0] hue_sf;
	logic [SAT_W-1:0] sat_sf;
	logic [LIT_W-1:0] lit_sf;

	assign hq_fin = hq_sd[NDIV];
	assign hue_c  = (hq_fin >= TURN_Q) ? hq_fin - TURN_Q : hq_fin;
	assign rdy_sf = !v_sf || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sf <= 1'b0;
		end else if (rdy_sf) begin
			v_sf <= v_sd[NDIV];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_sf && v_sd[NDIV]) begin
			hue_sf <= gray_sd[NDIV] ? '0 : HUE_W'(hue_c);
			sat_sf <= gray_sd[NDIV] ? '0 : SAT_W'(sq_sd[NDIV]);
			lit_sf <= LIT_W'(sum_sd[NDIV]);
		end
	end

	assign m_axis_tvalid = v_sf;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, lit_sf, sat_sf, hue_sf};

endmodule
